[rtl/modbus_response_frame_checker_defines.svh]
// Assertion macros for the Modbus response frame checker.
// No dependencies; taken in by the checker file.
`ifndef MODBUS_RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define MODBUS_RESPONSE_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, clocked on aclk, quiet during reset.
`define MRFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on aclk, quiet during reset.
`define MRFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mrfc_pkg.sv]
// Shared types and constants of the Modbus response frame checker.
// No dependencies.
package mrfc_pkg;

    // command codes on s_tuser
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CRC     = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [8:0]  START_LEN  = 9'd5;
    localparam logic [8:0]  HEADER_LEN = 9'd3;
    localparam logic [3:0]  RETRY_MAX  = 4'd15;
    localparam logic [3:0]  RETRY_RST  = 4'd3;

    // one result item
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [1:0] status;
        logic [8:0] frame_length;
        logic       last;
    } res_t;

    // front to queue
    typedef struct packed {
        logic push;
        res_t res;
    } push_t;

    // queue to back
    typedef struct packed {
        logic not_empty;
        res_t res;
    } head_t;

endpackage

[rtl/modbus_response_frame_checker.sv]
// Modbus RTU response frame checker, top level. Uses mrfc_pkg, mrfc_front, mrfc_fifo and mrfc_back.
// Throughput: one transfer per cycle while the queue is not full; CRC-16 byte update in the front end.
// Path: a result is written into the queue at the edge that accepts its input transfer, then is
// loaded from the queue head into the output register once that register is empty or m_tready is high.
// Reset: synchronous, active low aresetn; idle, CRC 0xFFFF, frame length 5, max_retries 3,
// queue and output register empty. No clearing pass.
module modbus_response_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,  // [3:0] max_retries
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_byte, [15:8] byte_index, [17:16] status,
                                   // [26:18] frame_length, [31:27] zero
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast    // last
);

    mrfc_pkg::push_t q_push;
    mrfc_pkg::head_t q_head;
    logic            q_full;
    logic            q_pop;

    // The register port never stalls; writes must only come while idle, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    // Front end: frame state, CRC and byte classification. Back-pressure
    // reaches s_tready only through a full queue.
    mrfc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tuser),
        .in_byte   (s_tdata),
        .in_ready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push)
    );

    // Short queue so the two sides stall independently.
    mrfc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_push),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head)
    );

    // Output register: holds a result until the transfer on m_ completes.
    mrfc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/mrfc_front.sv]
// Front end: accepts commands and bytes, keeps the frame state and CRC,
// and classifies each byte into a result for the queue. Uses mrfc_pkg.
module mrfc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [1:0]          in_cmd,
    input  logic [7:0]          in_byte,
    output logic                in_ready,
    input  logic                cfg_valid,
    input  logic [3:0]          cfg_data,
    input  logic                q_full,
    output mrfc_pkg::push_t     q_push
);

    logic        active_reg, active_next;
    logic [8:0]  rcvd_reg, rcvd_next;
    logic [8:0]  exp_reg, exp_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [3:0]  retry_reg, retry_next;
    logic [3:0]  max_retries_reg;

    logic        accept;
    logic [9:0]  pos_ext;
    logic [9:0]  exp_eff;
    logic [8:0]  exp_hdr;
    logic [15:0] crc_upd;
    logic [3:0]  retry_inc;
    logic [8:0]  idx_full;

    // reflected CRC-16, one byte per call, bit steps unrolled
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mrfc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign pos_ext   = {1'b0, rcvd_reg};
    assign exp_hdr   = mrfc_pkg::HEADER_LEN + {1'b0, in_byte} + 9'd2;
    assign exp_eff   = (rcvd_reg == 9'd2) ? {1'b0, exp_hdr} : {1'b0, exp_reg};
    assign crc_upd   = crc_byte(crc_reg, in_byte);
    assign retry_inc = (retry_reg == mrfc_pkg::RETRY_MAX) ? retry_reg : retry_reg + 4'd1;
    assign idx_full  = rcvd_reg - mrfc_pkg::HEADER_LEN;

    always_comb begin
        active_next = active_reg;
        rcvd_next   = rcvd_reg;
        exp_next    = exp_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        retry_next  = retry_reg;
        q_push      = '0;
        if (accept) begin
            case (in_cmd)
                mrfc_pkg::CMD_START: begin
                    active_next = 1'b1;
                    rcvd_next   = '0;
                    exp_next    = mrfc_pkg::START_LEN;
                    crc_next    = mrfc_pkg::CRC_INIT;
                    crc_lo_next = '0;
                    retry_next  = '0;
                end
                mrfc_pkg::CMD_BYTE: begin
                    if (active_reg) begin
                        rcvd_next = rcvd_reg + 9'd1;
                        exp_next  = exp_eff[8:0];
                        // CRC covers all but the two trailing CRC bytes
                        if (pos_ext + 10'd2 < {1'b0, exp_reg}) begin
                            crc_next = crc_upd;
                        end
                        if (pos_ext + 10'd1 == exp_eff) begin
                            active_next                 = 1'b0;
                            q_push.push                 = 1'b1;
                            q_push.res.kind             = 1'b1;
                            q_push.res.last             = 1'b1;
                            q_push.res.frame_length     = rcvd_next;
                            q_push.res.status = ({in_byte, crc_lo_reg} == crc_next) ?
                                                mrfc_pkg::ST_OK : mrfc_pkg::ST_CRC;
                        end else if (pos_ext + 10'd2 == exp_eff) begin
                            crc_lo_next = in_byte;
                        end else if (rcvd_reg >= mrfc_pkg::HEADER_LEN) begin
                            q_push.push           = 1'b1;
                            q_push.res.data_byte  = in_byte;
                            q_push.res.byte_index = idx_full[7:0];
                        end
                    end
                end
                mrfc_pkg::CMD_TICK: begin
                    if (active_reg) begin
                        retry_next = retry_inc;
                        if (retry_inc >= max_retries_reg) begin
                            active_next             = 1'b0;
                            q_push.push             = 1'b1;
                            q_push.res.kind         = 1'b1;
                            q_push.res.last         = 1'b1;
                            q_push.res.status       = mrfc_pkg::ST_TIMEOUT;
                            q_push.res.frame_length = rcvd_reg;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            rcvd_reg        <= '0;
            exp_reg         <= mrfc_pkg::START_LEN;
            crc_reg         <= mrfc_pkg::CRC_INIT;
            crc_lo_reg      <= '0;
            retry_reg       <= '0;
            max_retries_reg <= mrfc_pkg::RETRY_RST;
        end else begin
            active_reg <= active_next;
            rcvd_reg   <= rcvd_next;
            exp_reg    <= exp_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
            retry_reg  <= retry_next;
            if (cfg_valid) begin
                max_retries_reg <= cfg_data;
            end
        end
    end

endmodule

[rtl/mrfc_fifo.sv]
// Two-entry result queue between front end and output stage.
// Uses mrfc_pkg.
module mrfc_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  mrfc_pkg::push_t   wr,
    output logic              full,
    input  logic              pop,
    output mrfc_pkg::head_t   head
);

    mrfc_pkg::res_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full           = (count_reg == 2'd2);
    assign do_pop         = pop && (count_reg != 2'd0);
    assign head.not_empty = (count_reg != 2'd0);
    assign head.res       = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (wr.push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!wr.push && do_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.push) begin
            mem_reg[wr_ptr_reg] <= wr.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (wr.push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

[rtl/mrfc_back.sv]
// Output stage: registered result stream, refilled from the queue head.
// Uses mrfc_pkg.
module mrfc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  mrfc_pkg::head_t   head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    logic           valid_reg;
    mrfc_pkg::res_t res_reg;
    logic           load;

    assign load = !valid_reg || m_tready;
    assign pop  = load && head.not_empty;

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {5'd0, res_reg.frame_length, res_reg.status,
                       res_reg.byte_index, res_reg.data_byte};

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= head.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= head.not_empty;
        end
    end

endmodule

[rtl/mrfc_checker.sv]
// Port-level checks on the result stream of the frame checker, with bind.
// Uses modbus_response_frame_checker_defines.svh.
`include "modbus_response_frame_checker_defines.svh"

module mrfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    `MRFC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `MRFC_ASSERT_NOW(a_last_kind, m_tvalid, m_tlast == m_tuser,
        "tlast differs from status kind")
    `MRFC_ASSERT_NOW(a_data_clean, m_tvalid && !m_tuser, m_tdata[31:16] == 16'd0,
        "data transfer carries status bits")
    `MRFC_ASSERT_NOW(a_status_clean, m_tvalid && m_tuser,
        m_tdata[15:0] == 16'd0 && m_tdata[31:27] == 5'd0 && m_tdata[17:16] != 2'd3,
        "malformed status transfer")

endmodule

bind modbus_response_frame_checker mrfc_checker u_mrfc_checker (.*);

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for modbus_response_frame_checker: drives response bytes, ticks and
// starts on the s_ stream, predicts every m_ result in a scoreboard class and compares.
// Depends on mrfc_pkg and the checker RTL only.
module tb;

    // command code the block must ignore
    localparam logic [1:0] CMD_NONE = 2'd3;
    // quiet cycles after the last expected result before a register write or the end
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    // predicts results from accepted transfers and checks what the block delivers
    class frame_scoreboard;
        logic [3:0]       max_retries;
        bit               active;
        int               rcvd;
        int               exp_len;
        logic [15:0]      crc;
        logic [7:0]       crc_lo;
        logic [3:0]       retries;
        mrfc_pkg::res_t   pending_results[$];
        int               errors;

        function new();
            max_retries = mrfc_pkg::RETRY_RST;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            active  = 1'b0;
            rcvd    = 0;
            exp_len = int'(mrfc_pkg::START_LEN);
            crc     = mrfc_pkg::CRC_INIT;
            crc_lo  = 8'h00;
            retries = 4'd0;
        endfunction

        // bytewise CRC-16, reflected
        function logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] v;
            v = c ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
                v = v[0] ? ((v >> 1) ^ mrfc_pkg::CRC_POLY) : (v >> 1);
            return v;
        endfunction

        function void note_rx(input logic [1:0] cmd, input logic [7:0] b);
            mrfc_pkg::res_t r;
            int             pos;
            r = '0;
            if (cmd == mrfc_pkg::CMD_START) begin
                clear_frame();
                active = 1'b1;
                return;
            end
            if (!active || cmd == CMD_NONE)
                return;
            if (cmd == mrfc_pkg::CMD_TICK) begin
                if (retries != mrfc_pkg::RETRY_MAX)
                    retries++;
                if (retries >= max_retries) begin
                    r.kind = 1'b1;
                    r.status = mrfc_pkg::ST_TIMEOUT;
                    r.frame_length = rcvd[8:0];
                    r.last = 1'b1;
                    pending_results.push_back(r);
                    active = 1'b0;
                end
                return;
            end
            pos  = rcvd;
            rcvd = pos + 1;
            if (pos + 2 < exp_len)
                crc = crc16_next(crc, b);
            if (pos == 2)
                exp_len = int'(mrfc_pkg::HEADER_LEN) + int'(b) + 2;
            if (pos + 1 == exp_len) begin
                // last CRC byte: high half of the transmitted CRC
                r.kind = 1'b1;
                r.status = ({b, crc_lo} == crc) ? mrfc_pkg::ST_OK : mrfc_pkg::ST_CRC;
                r.frame_length = rcvd[8:0];
                r.last = 1'b1;
                pending_results.push_back(r);
                active = 1'b0;
            end else if (pos + 2 == exp_len) begin
                crc_lo = b;
            end else if (pos >= int'(mrfc_pkg::HEADER_LEN)) begin
                r.data_byte = b;
                r.byte_index = 8'(pos - int'(mrfc_pkg::HEADER_LEN));
                pending_results.push_back(r);
            end
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task cmp_field(input string name, input logic [8:0] got, input logic [8:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(input mrfc_pkg::res_t got);
            mrfc_pkg::res_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing pending: %p", got));
                return;
            end
            want = pending_results.pop_front();
            cmp_field("kind", 9'(got.kind), 9'(want.kind));
            cmp_field("data_byte", 9'(got.data_byte), 9'(want.data_byte));
            cmp_field("byte_index", 9'(got.byte_index), 9'(want.byte_index));
            cmp_field("status", 9'(got.status), 9'(want.status));
            cmp_field("frame_length", got.frame_length, want.frame_length);
            cmp_field("last", 9'(got.last), 9'(want.last));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic [1:0]  s_tuser;   // [1:0] command
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;  // [3:0] max_retries
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [7:0] data_byte, [15:8] byte_index, [17:16] status,
                            // [26:18] frame_length, [31:27] zero
    logic        m_tuser;   // [0] kind
    logic        m_tlast;   // last

    frame_scoreboard sb = new();
    int  items_sent = 0;
    bit  hold_req = 1'b0;
    bit  steady[2] = '{1'b0, 1'b0};

    modbus_response_frame_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // wait before a transfer, drawn at random per side, with the odd stretch of back-to-back traffic
    function automatic int draw_gap(input int side);
        if ($urandom_range(0, 39) == 0)
            steady[side] = !steady[side];
        return steady[side] ? 0 : $urandom_range(0, 17);
    endfunction

    // one s_ transfer; s_tvalid stays high if the next item follows with no gap
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
        int gap;
        gap = draw_gap(0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_rx(cmd, b);
        items_sent++;
    endtask

    // start + addr + func + count + data + CRC; optional burst of ticks before byte tick_at
    task automatic send_response(input int count, input bit bad_crc,
                                 input int tick_at, input int n_ticks);
        int          len;
        logic [15:0] c;
        logic [15:0] sent_crc;
        logic [7:0]  b;
        len = count + 5;
        c = mrfc_pkg::CRC_INIT;
        sent_crc = '0;
        send_item(mrfc_pkg::CMD_START, 8'($urandom));
        for (int i = 0; i < len; i++) begin
            if (i == tick_at)
                repeat (n_ticks) send_item(mrfc_pkg::CMD_TICK, 8'($urandom));
            if (i == 2)
                b = 8'(count);
            else if (i == len - 2) begin
                sent_crc = c ^ (bad_crc ? 16'($urandom_range(1, 65535)) : 16'h0000);
                b = sent_crc[7:0];
            end else if (i == len - 1)
                b = sent_crc[15:8];
            else
                b = 8'($urandom);
            if (i < len - 2)
                c = sb.crc16_next(c, b);
            send_item(mrfc_pkg::CMD_BYTE, b);
        end
    endtask

    // let every pending result out, then a quiet drain wait for items with no result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_max_retries(input logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.max_retries = v;
    endtask

    // result receiver: per-transfer stall, plus one long hold-off on request
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            gap = draw_gap(1);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        mrfc_pkg::res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind         = m_tuser;
            got.data_byte    = m_tdata[7:0];
            got.byte_index   = m_tdata[15:8];
            got.status       = m_tdata[17:16];
            got.frame_length = m_tdata[26:18];
            got.last         = m_tlast;
            sb.check_result(got);
        end
    end

    // stimulus
    initial begin
        logic [3:0] settings[5];
        int         target;
        int         r;
        int         count;
        int         len;
        settings = '{4'd15, 4'd1, 4'd0, 4'd7, 4'($urandom_range(2, 14))};
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tuser   <= mrfc_pkg::CMD_START;
        cfg_valid <= 1'b0;
        cfg_data  <= 4'd0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, retry limit at its reset value
        send_item(mrfc_pkg::CMD_BYTE, 8'hFF);   // idle: ignored
        send_item(mrfc_pkg::CMD_TICK, 8'h00);
        send_item(CMD_NONE, 8'h5A);
        send_response(1, 1'b0, -1, 0);          // one data byte, good CRC
        send_item(mrfc_pkg::CMD_START, 8'h00);
        send_item(mrfc_pkg::CMD_BYTE, 8'h11);
        send_response(0, 1'b1, -1, 0);          // restart, empty data area, bad CRC
        send_item(mrfc_pkg::CMD_START, 8'hA5);
        send_item(CMD_NONE, 8'hFF);
        send_item(mrfc_pkg::CMD_TICK, 8'hFF);
        send_item(mrfc_pkg::CMD_TICK, 8'h00);
        send_item(mrfc_pkg::CMD_BYTE, 8'h00);   // bytes leave the retry count alone
        send_item(mrfc_pkg::CMD_TICK, 8'h55);   // third tick: timeout after one byte
        wait_drained();
        set_max_retries(4'd0);
        send_item(mrfc_pkg::CMD_START, 8'h00);
        send_item(mrfc_pkg::CMD_TICK, 8'h00);   // zero limit: first tick ends the frame

        // random phases, one retry limit each
        target = items_sent;
        foreach (settings[p]) begin
            wait_drained();
            set_max_retries(settings[p]);
            target += 210;
            if (p == 0) begin
                // long m_ hold-off while a big frame keeps coming
                hold_req = 1'b1;
                send_response(120, 1'b0, -1, 0);
            end
            while (items_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    send_item(2'($urandom_range(0, 3)), 8'($urandom));
                end else if (r < 14) begin
                    // truncated frame, dropped by the next start
                    send_item(mrfc_pkg::CMD_START, 8'($urandom));
                    repeat ($urandom_range(1, 6))
                        send_item(mrfc_pkg::CMD_BYTE, 8'($urandom));
                end else begin
                    if ($urandom_range(0, 59) == 0)
                        count = $urandom_range(0, 1) ? 255 : $urandom_range(9, 254);
                    else
                        count = $urandom_range(0, 8);
                    len = count + 5;
                    if ($urandom_range(0, 3) == 0)
                        send_response(count, $urandom_range(0, 4) == 0,
                                      $urandom_range(0, len - 1),
                                      $urandom_range(1, settings[p] + 1));
                    else
                        send_response(count, $urandom_range(0, 4) == 0, -1, 0);
                end
            end
        end

        wait_drained();
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end
endmodule
